[hw/rtl/ess_pkg.sv]
// ess_pkg: shared widths, codes and the table entry layout of the ellipsoid
// shell size field. No dependencies; used by the channel interfaces, the RAM
// user and the top level.
package ess_pkg;

    localparam int MAX_ELLIPSOIDS_DEF = 16;

    localparam int LEN_W      = 31;
    localparam int OBL_W      = 17;
    localparam int PNT_W      = 32;
    localparam int ANG_W      = 18;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ROT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ROT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REGION_INNER   = 2'd0;
    localparam logic [1:0] REGION_SHELL   = 2'd1;
    localparam logic [1:0] REGION_OUTSIDE = 2'd2;

    localparam logic ERR_OK       = 1'b0;
    localparam logic ERR_NO_SHELL = 1'b1;

    localparam logic [OBL_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [LEN_W-1:0] LEN_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [OBL_W-1:0] air;
        logic [OBL_W-1:0] earth;
        logic [OBL_W-1:0] horiz;
        logic [LEN_W-1:0] edge_len;
        logic [LEN_W-1:0] radius;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // oblateness above one acts as one
    function automatic logic [OBL_W-1:0] sat_obl(input logic [OBL_W-1:0] o);
        return (o > ONE_Q16) ? ONE_Q16 : o;
    endfunction

endpackage

[hw/rtl/ess_if.sv]
// ess_in_if / ess_out_if: valid-ready channels carrying one input item and
// one result item. Depends on ess_pkg for the field widths.
interface ess_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [ess_pkg::IDX_W-1:0]           entry_index;
    logic [ess_pkg::LEN_W-1:0]           radius;
    logic [ess_pkg::LEN_W-1:0]           edge_len;
    logic [ess_pkg::OBL_W-1:0]           obl_horiz;
    logic [ess_pkg::OBL_W-1:0]           obl_earth;
    logic [ess_pkg::OBL_W-1:0]           obl_air;
    logic signed [ess_pkg::PNT_W-1:0]    point_x;
    logic signed [ess_pkg::PNT_W-1:0]    point_y;
    logic signed [ess_pkg::PNT_W-1:0]    point_z;

    modport source
    (
        output valid, opcode, entry_index, radius, edge_len, obl_horiz, obl_earth,
               obl_air, point_x, point_y, point_z,
        input  ready
    );
    modport sink
    (
        input  valid, opcode, entry_index, radius, edge_len, obl_horiz, obl_earth,
               obl_air, point_x, point_y, point_z,
        output ready
    );
endinterface

interface ess_out_if;
    logic                        valid;
    logic                        ready;
    logic [ess_pkg::LEN_W-1:0]   max_edge;
    logic [1:0]                  region;
    logic [ess_pkg::IDX_W-1:0]   shell_index;
    logic                        error_code;

    modport source
    (
        output valid, max_edge, region, shell_index, error_code,
        input  ready
    );
    modport sink
    (
        input  valid, max_edge, region, shell_index, error_code,
        output ready
    );
endinterface

[hw/rtl/ess_ram.sv]
// ess_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ess_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ellipsoid_shell_size_field.sv]
// ellipsoid_shell_size_field: top level, sequencer around one shared multiplier,
// one shift-subtract divider and one bit-pair square root unit.
// Depends on ess_pkg, ess_if (ess_in_if, ess_out_if) and ess_ram.
//
// Usage
//   in_ch carries loads (opcode load) and queries (opcode query). A load writes
//   one table entry and gives no result; a query gives one beat on out_ch.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets centre, rotation
//   and ellipsoid count; write it only while the block is idle.
// Timing
//   A query walks the table: rotation, a degeneracy check of each ellipsoid,
//   then the ellipsoid evaluations (fewer steps where a ratio saturates) for
//   between one and count + 1 evaluations, then the two square roots and the
//   interpolation. The serial divider (31 steps per axis ratio) sets the pace.
//   in_ch.ready is high only between queries.
// Reset
//   Configuration returns to centre 0, cos 1.0, sin 0, count 1; the table is
//   not cleared and must be loaded before it is queried.
// Stall
//   The result sits in an output register; the block takes the next item while
//   it waits, and a finished query holds until that register is free.
module ellipsoid_shell_size_field #(
    parameter int MAX_ELLIPSOIDS = ess_pkg::MAX_ELLIPSOIDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ess_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ess_pkg::CFG_DATA_W-1:0]   cfg_data,
    ess_in_if.sink                           in_ch,
    ess_out_if.source                        out_ch
);

    localparam int AW = (MAX_ELLIPSOIDS > 1) ? $clog2(MAX_ELLIPSOIDS) : 1;
    localparam int NW = 9;
    localparam logic [NW-1:0] N_MAX = NW'(MAX_ELLIPSOIDS);
    localparam logic [31:0] ONE_Q20 = 32'd1 << 20;
    localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
    localparam logic [51:0] HALF_Q20 = 52'd1 << 19;

    typedef enum logic [4:0] {
        S_IDLE, S_ROT, S_DEG_RD, S_DEG_CHK, S_Q_RD, S_Q_AX, S_DIV_LD, S_DIV_RUN,
        S_SQR, S_ACC, S_SQRT_LD, S_SQRT_RUN, S_T_MUL, S_T_DIV_LD, S_EDGE, S_FIN,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST, PH_LAST, PH_SCAN
    } phase_t;

    // configuration
    logic signed [31:0]               center_x_reg, center_y_reg, center_z_reg;
    logic signed [ess_pkg::ANG_W-1:0] cos_reg, sin_reg;
    logic [ess_pkg::CNT_W-1:0]        count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            cos_reg      <= 18'sd65536;
            sin_reg      <= '0;
            count_reg    <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ess_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                ess_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                ess_pkg::CFG_CENTER_Z: center_z_reg <= cfg_data;
                ess_pkg::CFG_COS_ROT:  cos_reg      <= cfg_data[ess_pkg::ANG_W-1:0];
                ess_pkg::CFG_SIN_ROT:  sin_reg      <= cfg_data[ess_pkg::ANG_W-1:0];
                ess_pkg::CFG_COUNT:    count_reg    <= cfg_data[ess_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    state_t             state_reg;
    phase_t             phase_reg;
    logic [2:0]         sub_reg;
    logic [1:0]         axis_reg;
    logic [5:0]         cnt_reg;
    logic               div_t_reg;
    logic               sq_sel_reg;
    logic [NW-1:0]      idx_reg, n_reg;
    logic               out_valid_reg;

    // datapath
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic signed [51:0] vx_reg, vy_reg;
    logic [50:0]        mx_reg, my_reg, mz_reg;
    logic               air_reg;
    logic [30:0]        ent_r_reg, ent_e_reg, prev_e_reg;
    logic [16:0]        ent_ov_reg;
    logic [46:0]        b_reg, c_reg;
    logic [46:0]        den_reg, rem_reg;
    logic [30:0]        bits_reg, quo_reg, ratio_reg;
    logic [63:0]        q_acc_reg, prev_q_reg, cur_q_reg;
    logic [63:0]        sv_reg, sr_reg, sb_reg;
    logic [31:0]        s0_reg, s1_reg;
    logic [20:0]        t_reg;
    logic [30:0]        res_edge_reg, out_edge_reg;
    logic [1:0]         res_region_reg, out_region_reg;
    logic [3:0]         res_shell_reg, out_shell_reg;
    logic               res_err_reg, out_err_reg;
    logic signed [65:0] mp_reg;

    // table
    logic                           ram_we;
    logic [NW-1:0]                  load_idx;
    logic [ess_pkg::ENTRY_W-1:0]    ram_rdata;
    ess_pkg::entry_t                wr_ent, rd_ent;
    logic                           in_beat;

    assign in_beat  = in_ch.valid && in_ch.ready;
    assign load_idx = {5'b0, in_ch.entry_index};
    assign ram_we   = in_beat && (in_ch.opcode == ess_pkg::OP_LOAD) && (load_idx < N_MAX);

    always_comb
    begin
        wr_ent.air      = in_ch.obl_air;
        wr_ent.earth    = in_ch.obl_earth;
        wr_ent.horiz    = in_ch.obl_horiz;
        wr_ent.edge_len = in_ch.edge_len;
        wr_ent.radius   = in_ch.radius;
    end

    ess_ram #(
        .WIDTH (ess_pkg::ENTRY_W),
        .DEPTH (MAX_ELLIPSOIDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_idx[AW-1:0]),
        .wdata (wr_ent),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_ent = ess_pkg::entry_t'(ram_rdata);

    // entry checks
    logic [16:0] oh_sat, ov_sat;
    logic        degenerate;

    assign oh_sat     = ess_pkg::sat_obl(rd_ent.horiz);
    assign ov_sat     = ess_pkg::sat_obl(air_reg ? rd_ent.air : rd_ent.earth);
    assign degenerate = (rd_ent.radius == '0) || (oh_sat == ess_pkg::ONE_Q16)
                        || (ov_sat == ess_pkg::ONE_Q16);

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        s0_off;
    logic [30:0]        e_diff;
    logic               e_up;

    assign s0_off = s0_reg - ONE_Q20;
    assign e_up   = ent_e_reg >= prev_e_reg;
    assign e_diff = e_up ? (ent_e_reg - prev_e_reg) : (prev_e_reg - ent_e_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ROT:
            begin
                case (sub_reg)
                    3'd0:
                    begin
                        mul_a = dx_reg;
                        mul_b = {{15{cos_reg[17]}}, cos_reg};
                    end
                    3'd1:
                    begin
                        mul_a = dy_reg;
                        mul_b = {{15{sin_reg[17]}}, sin_reg};
                    end
                    3'd2:
                    begin
                        mul_a = dy_reg;
                        mul_b = {{15{cos_reg[17]}}, cos_reg};
                    end
                    3'd3:
                    begin
                        mul_a = dx_reg;
                        mul_b = {{15{sin_reg[17]}}, sin_reg};
                    end
                    default: ;
                endcase
            end
            S_Q_AX:
            begin
                if (sub_reg == 3'd0)
                begin
                    mul_a = {2'b0, rd_ent.radius};
                    mul_b = {16'b0, ess_pkg::ONE_Q16 - oh_sat};
                end
                else
                begin
                    mul_a = {2'b0, ent_r_reg};
                    mul_b = {16'b0, ess_pkg::ONE_Q16 - ent_ov_reg};
                end
            end
            S_SQR:
            begin
                mul_a = {2'b0, ratio_reg};
                mul_b = {2'b0, ratio_reg};
            end
            S_T_MUL:
            begin
                mul_a = {1'b0, s1_reg};
                mul_b = {1'b0, s0_off};
            end
            S_EDGE:
            begin
                mul_a = {12'b0, t_reg};
                mul_b = {2'b0, e_diff};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        mp_reg <= mul_p;
    end

    // rotation magnitudes
    logic signed [51:0] vx_neg, vy_neg;
    logic signed [32:0] dz_neg;

    assign vx_neg = -vx_reg;
    assign vy_neg = -vy_reg;
    assign dz_neg = -dz_reg;

    // shared divider, one quotient bit a cycle
    logic [50:0] num_sel;
    logic [46:0] den_sel;
    logic [39:0] top_sel;
    logic        ratio_sat;
    logic [47:0] div_cand, div_sub;
    logic        div_ge;
    logic [46:0] rem_step;
    logic [30:0] quo_step;

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                num_sel = mx_reg;
                den_sel = {ent_r_reg, 16'b0};
            end
            2'd1:
            begin
                num_sel = my_reg;
                den_sel = b_reg;
            end
            default:
            begin
                num_sel = mz_reg;
                den_sel = c_reg;
            end
        endcase
    end

    assign top_sel   = num_sel[50:11];
    assign ratio_sat = {7'b0, top_sel} >= den_sel;
    assign div_cand  = {rem_reg, bits_reg[30]};
    assign div_ge    = div_cand >= {1'b0, den_reg};
    assign div_sub   = div_cand - {1'b0, den_reg};
    assign rem_step  = div_ge ? div_sub[46:0] : div_cand[46:0];
    assign quo_step  = {quo_reg[29:0], div_ge};

    // square root, one result bit a cycle
    logic [63:0] sq_try, sr_step, sv_step;
    logic        sq_ge;

    assign sq_try  = sr_reg + sb_reg;
    assign sq_ge   = sv_reg >= sq_try;
    assign sr_step = sq_ge ? ((sr_reg >> 1) + sb_reg) : (sr_reg >> 1);
    assign sv_step = sq_ge ? (sv_reg - sq_try) : sv_reg;

    // quadratic form and final edge
    logic [63:0] q_sum;
    logic        q_inside;
    logic [51:0] e_rnd;
    logic [31:0] e_adj;
    logic [30:0] e_fin;
    logic [NW-1:0] n_in;

    assign q_sum    = q_acc_reg + mp_reg[63:0];
    assign q_inside = q_sum <= ONE_Q40;
    assign e_rnd    = mp_reg[51:0] + HALF_Q20;
    assign e_adj    = e_rnd[51:20];
    assign e_fin    = e_up ? (prev_e_reg + e_adj[30:0]) : (prev_e_reg - e_adj[30:0]);

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_in = 9'd1;
        end
        else if ({4'b0, count_reg} > N_MAX)
        begin
            n_in = N_MAX;
        end
        else
        begin
            n_in = {4'b0, count_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FIRST;
            sub_reg        <= '0;
            axis_reg       <= '0;
            cnt_reg        <= '0;
            div_t_reg      <= 1'b0;
            sq_sel_reg     <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= 9'd1;
            out_valid_reg  <= 1'b0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            dz_reg         <= '0;
            vx_reg         <= '0;
            vy_reg         <= '0;
            mx_reg         <= '0;
            my_reg         <= '0;
            mz_reg         <= '0;
            air_reg        <= 1'b0;
            ent_r_reg      <= '0;
            ent_e_reg      <= '0;
            prev_e_reg     <= '0;
            ent_ov_reg     <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            den_reg        <= '0;
            rem_reg        <= '0;
            bits_reg       <= '0;
            quo_reg        <= '0;
            ratio_reg      <= '0;
            q_acc_reg      <= '0;
            prev_q_reg     <= '0;
            cur_q_reg      <= '0;
            sv_reg         <= '0;
            sr_reg         <= '0;
            sb_reg         <= '0;
            s0_reg         <= '0;
            s1_reg         <= '0;
            t_reg          <= '0;
            res_edge_reg   <= '0;
            res_region_reg <= ess_pkg::REGION_INNER;
            res_shell_reg  <= '0;
            res_err_reg    <= ess_pkg::ERR_OK;
            out_edge_reg   <= '0;
            out_region_reg <= ess_pkg::REGION_INNER;
            out_shell_reg  <= '0;
            out_err_reg    <= ess_pkg::ERR_OK;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat && (in_ch.opcode == ess_pkg::OP_QUERY))
                    begin
                        dx_reg    <= {in_ch.point_x[31], in_ch.point_x}
                                     - {center_x_reg[31], center_x_reg};
                        dy_reg    <= {in_ch.point_y[31], in_ch.point_y}
                                     - {center_y_reg[31], center_y_reg};
                        dz_reg    <= {in_ch.point_z[31], in_ch.point_z}
                                     - {center_z_reg[31], center_z_reg};
                        n_reg     <= n_in;
                        idx_reg   <= '0;
                        sub_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                end

                S_ROT:
                begin
                    sub_reg <= sub_reg + 3'd1;
                    case (sub_reg)
                        3'd1: vx_reg <= mp_reg[51:0];
                        3'd2: vx_reg <= vx_reg + mp_reg[51:0];
                        3'd3: vy_reg <= mp_reg[51:0];
                        3'd4: vy_reg <= vy_reg - mp_reg[51:0];
                        3'd5:
                        begin
                            mx_reg    <= vx_reg[51] ? vx_neg[50:0] : vx_reg[50:0];
                            my_reg    <= vy_reg[51] ? vy_neg[50:0] : vy_reg[50:0];
                            mz_reg    <= {3'b0, (dz_reg[32] ? dz_neg[31:0] : dz_reg[31:0]),
                                          16'b0};
                            air_reg   <= dz_reg[32];
                            state_reg <= S_DEG_RD;
                        end
                        default: ;
                    endcase
                end

                S_DEG_RD:
                begin
                    state_reg <= S_DEG_CHK;
                end

                S_DEG_CHK:
                begin
                    if (degenerate)
                    begin
                        res_edge_reg   <= '0;
                        res_region_reg <= ess_pkg::REGION_INNER;
                        res_shell_reg  <= '0;
                        res_err_reg    <= ess_pkg::ERR_NO_SHELL;
                        state_reg      <= S_OUT;
                    end
                    else if (idx_reg == n_reg - 9'd1)
                    begin
                        idx_reg   <= '0;
                        phase_reg <= PH_FIRST;
                        state_reg <= S_Q_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 9'd1;
                        state_reg <= S_DEG_RD;
                    end
                end

                S_Q_RD:
                begin
                    sub_reg   <= '0;
                    state_reg <= S_Q_AX;
                end

                S_Q_AX:
                begin
                    sub_reg <= sub_reg + 3'd1;
                    case (sub_reg)
                        3'd0:
                        begin
                            ent_r_reg  <= rd_ent.radius;
                            ent_e_reg  <= rd_ent.edge_len;
                            ent_ov_reg <= ov_sat;
                            q_acc_reg  <= '0;
                        end
                        3'd1: b_reg <= mp_reg[46:0];
                        default:
                        begin
                            c_reg     <= mp_reg[46:0];
                            axis_reg  <= '0;
                            state_reg <= S_DIV_LD;
                        end
                    endcase
                end

                S_DIV_LD:
                begin
                    div_t_reg <= 1'b0;
                    if (ratio_sat)
                    begin
                        ratio_reg <= ess_pkg::LEN_MAX;
                        state_reg <= S_SQR;
                    end
                    else
                    begin
                        den_reg   <= den_sel;
                        rem_reg   <= {7'b0, top_sel};
                        bits_reg  <= {num_sel[10:0], 20'b0};
                        quo_reg   <= '0;
                        cnt_reg   <= 6'd31;
                        state_reg <= S_DIV_RUN;
                    end
                end

                S_DIV_RUN:
                begin
                    rem_reg  <= rem_step;
                    bits_reg <= {bits_reg[29:0], 1'b0};
                    quo_reg  <= quo_step;
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        if (div_t_reg)
                        begin
                            t_reg     <= quo_step[20:0];
                            state_reg <= S_EDGE;
                        end
                        else
                        begin
                            ratio_reg <= quo_step;
                            state_reg <= S_SQR;
                        end
                    end
                end

                S_SQR:
                begin
                    state_reg <= S_ACC;
                end

                S_ACC:
                begin
                    q_acc_reg <= q_sum;
                    if (axis_reg != 2'd2)
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_DIV_LD;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_FIRST:
                            begin
                                prev_q_reg <= q_sum;
                                prev_e_reg <= ent_e_reg;
                                if (q_inside || n_reg == 9'd1)
                                begin
                                    res_edge_reg   <= ent_e_reg;
                                    res_region_reg <= q_inside ? ess_pkg::REGION_INNER
                                                               : ess_pkg::REGION_OUTSIDE;
                                    res_shell_reg  <= '0;
                                    res_err_reg    <= ess_pkg::ERR_OK;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    phase_reg <= PH_LAST;
                                    idx_reg   <= n_reg - 9'd1;
                                    state_reg <= S_Q_RD;
                                end
                            end
                            PH_LAST:
                            begin
                                if (!q_inside)
                                begin
                                    res_edge_reg   <= ent_e_reg;
                                    res_region_reg <= ess_pkg::REGION_OUTSIDE;
                                    res_shell_reg  <= idx_reg[3:0];
                                    res_err_reg    <= ess_pkg::ERR_OK;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    phase_reg <= PH_SCAN;
                                    idx_reg   <= 9'd1;
                                    state_reg <= S_Q_RD;
                                end
                            end
                            default:
                            begin
                                if (q_inside || idx_reg == n_reg - 9'd1)
                                begin
                                    cur_q_reg  <= q_sum;
                                    sq_sel_reg <= 1'b0;
                                    state_reg  <= S_SQRT_LD;
                                end
                                else
                                begin
                                    prev_q_reg <= q_sum;
                                    prev_e_reg <= ent_e_reg;
                                    idx_reg    <= idx_reg + 9'd1;
                                    state_reg  <= S_Q_RD;
                                end
                            end
                        endcase
                    end
                end

                S_SQRT_LD:
                begin
                    sv_reg    <= sq_sel_reg ? cur_q_reg : prev_q_reg;
                    sr_reg    <= '0;
                    sb_reg    <= 64'd1 << 62;
                    cnt_reg   <= 6'd32;
                    state_reg <= S_SQRT_RUN;
                end

                S_SQRT_RUN:
                begin
                    sv_reg  <= sv_step;
                    sr_reg  <= sr_step;
                    sb_reg  <= sb_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        if (!sq_sel_reg)
                        begin
                            s0_reg     <= sr_step[31:0];
                            sq_sel_reg <= 1'b1;
                            state_reg  <= S_SQRT_LD;
                        end
                        else
                        begin
                            s1_reg    <= sr_step[31:0];
                            state_reg <= S_T_MUL;
                        end
                    end
                end

                S_T_MUL:
                begin
                    if (s0_reg > s1_reg && s0_reg >= ONE_Q20)
                    begin
                        state_reg <= S_T_DIV_LD;
                    end
                    else
                    begin
                        t_reg     <= '0;
                        state_reg <= S_EDGE;
                    end
                end

                S_T_DIV_LD:
                begin
                    // quotient stays within 21 bits, so the top part is below the divisor
                    div_t_reg <= 1'b1;
                    den_reg   <= {15'b0, s0_reg - s1_reg};
                    rem_reg   <= {15'b0, mp_reg[52:21]};
                    bits_reg  <= {mp_reg[20:0], 10'b0};
                    quo_reg   <= '0;
                    cnt_reg   <= 6'd21;
                    state_reg <= S_DIV_RUN;
                end

                S_EDGE:
                begin
                    state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    res_edge_reg   <= e_fin;
                    res_region_reg <= ess_pkg::REGION_SHELL;
                    res_shell_reg  <= idx_reg[3:0];
                    res_err_reg    <= ess_pkg::ERR_OK;
                    state_reg      <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_edge_reg   <= res_edge_reg;
                        out_region_reg <= res_region_reg;
                        out_shell_reg  <= res_shell_reg;
                        out_err_reg    <= res_err_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.max_edge    = out_edge_reg;
    assign out_ch.region      = out_region_reg;
    assign out_ch.shell_index = out_shell_reg;
    assign out_ch.error_code  = out_err_reg;

`ifndef NO_ASSERTIONS
    // a result beat only appears from the hand-over state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside hand-over");

    // restoring divider keeps its partial remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_RUN) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // table walk never leaves the ellipsoids in use
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (idx_reg < n_reg))
        else $error("table index beyond ellipsoid count");

    // radial weight never exceeds one
    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (t_reg <= ONE_Q20[20:0]))
        else $error("interpolation weight above one");
`endif

endmodule
